// ===== sv/rcfs_pkg.sv =====
// Shared types and constants for the relative color feature similarity block.
// Used by rcfs_div and by the relative_color_feature_similarity top level.
`default_nettype none

package rcfs_pkg;

  // Field and state widths.
  localparam int FIELD_W  = 16;
  localparam int TOTAL_W  = 22;
  localparam int NUM_W    = 64;
  localparam int TSUM_W   = 19;
  localparam int PROD_W   = 51;
  localparam int SIM_W    = 17;

  // Divider geometry: 64-bit dividend, 37-bit divisor, 18 quotient bits.
  localparam int DVD_W    = 64;
  localparam int DVS_W    = 37;
  localparam int QUO_W    = 18;
  localparam int DSH_W    = DVS_W + QUO_W - 1;
  localparam int CNT_W    = 5;

  // Saturation limit of the population totals.
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // 1.0 in Q1.16.
  localparam logic [SIM_W-1:0] ONE_Q16 = 17'd65536;

  // Final divisor scale: 6 for the score average, 4096 for the Q4.12 weight.
  localparam logic [DVS_W-1:0] DIV_SCALE = 37'd24576;

  // Request to the shared divider.
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  // Response from the shared divider.
  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== sv/rcfs_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, 18 quotient bits.
// Depends on rcfs_pkg for the request and response structs.
`default_nettype none

module rcfs_div
  import rcfs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] rem;
  logic [DSH_W-1:0] dsh;
  logic [QUO_W-1:0] quo;
  logic             done;

  // Trial subtraction of the shifted divisor from the partial remainder.
  logic [DVD_W-1:0] dsh_ext;
  logic             fits;

  assign dsh_ext = {{(DVD_W-DSH_W){1'b0}}, dsh};
  assign fits    = (rem >= dsh_ext);

  // Control: run for QUO_W steps after a start request.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= CNT_W'(QUO_W - 1);
      end else if (run) begin
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Datapath: remainder, shifted divisor and quotient.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend;
      dsh <= {req.divisor, {(QUO_W-1){1'b0}}};
      quo <= '0;
    end else if (run) begin
      if (fits) begin
        rem <= rem - dsh_ext;
      end
      quo <= {quo[QUO_W-2:0], fits};
      dsh <= dsh >> 1;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

// ===== sv/relative_color_feature_similarity.sv =====
// Top level of the relative color feature similarity block: sequencer,
// shared multiplier, accumulators. Depends on rcfs_pkg and rcfs_div.
//
// Usage: one color entry is a request on start with the fields y_a, s_a,
// v_a, y_b, s_b, v_b, color_weight, ignored and last. A request is taken at
// a rising edge where start is high and busy is low. Busy stays high while
// the entry is worked on.
// A scored entry (not ignored, some Y nonzero) runs up to three ratio divisions
// on one shared radix-2 divider (none for a ratio whose larger value is zero),
// then two multiplies on one shared 32x19 multiplier and a saturating
// accumulate. Unscored entries skip the divisions and multiplies.
// On a last entry the numerator is divided by six times the larger total
// times 4096 on the same divider, and similarity is shown for exactly one
// cycle with done high. The receiver cannot stall; the result must be taken
// in that cycle. After the result all sums are cleared.
// Reset (rst, synchronous) clears the sums and returns to idle.
`default_nettype none

module relative_color_feature_similarity
  import rcfs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [FIELD_W-1:0] y_a,
  input  wire logic [FIELD_W-1:0] s_a,
  input  wire logic [FIELD_W-1:0] v_a,
  input  wire logic [FIELD_W-1:0] y_b,
  input  wire logic [FIELD_W-1:0] s_b,
  input  wire logic [FIELD_W-1:0] v_b,
  input  wire logic [FIELD_W-1:0] color_weight,
  input  wire logic               ignored,
  input  wire logic               last,
  output logic                    done,
  output logic [SIM_W-1:0]        similarity
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_RLAUNCH = 8'b0000_0010,
    S_RWAIT   = 8'b0000_0100,
    S_MUL1    = 8'b0000_1000,
    S_MUL2    = 8'b0001_0000,
    S_ACCUM   = 8'b0010_0000,
    S_FLAUNCH = 8'b0100_0000,
    S_FWAIT   = 8'b1000_0000
  } state_t;

  localparam logic [1:0] IDX_Y = 2'd0;
  localparam logic [1:0] IDX_S = 2'd1;
  localparam logic [1:0] IDX_V = 2'd2;

  state_t state;

  // Captured entry.
  logic [FIELD_W-1:0] ya, sa, va, yb, sb, vb, wgt;
  logic               last_r;

  // Sums and working registers.
  logic [TOTAL_W-1:0] total_pop_a, total_pop_b;
  logic [NUM_W-1:0]   weighted_numerator;
  logic [TSUM_W-1:0]  tsum;
  logic [PROD_W-1:0]  prod;
  logic [1:0]         idx;

  div_req_t div_req;
  div_rsp_t div_rsp;

  rcfs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Saturating population totals for the incoming entry.
  logic [TOTAL_W:0]   sum_a, sum_b;
  logic [TOTAL_W-1:0] total_a_next, total_b_next;

  assign sum_a = {1'b0, total_pop_a} + (TOTAL_W+1)'(y_a);
  assign sum_b = {1'b0, total_pop_b} + (TOTAL_W+1)'(y_b);
  assign total_a_next = sum_a[TOTAL_W] ? TOTAL_MAX : sum_a[TOTAL_W-1:0];
  assign total_b_next = sum_b[TOTAL_W] ? TOTAL_MAX : sum_b[TOTAL_W-1:0];

  // Operand pair of the current ratio.
  logic [FIELD_W-1:0] op_a, op_b, op_hi, op_lo;
  always_comb begin
    case (idx)
      IDX_Y:   begin op_a = ya; op_b = yb; end
      IDX_S:   begin op_a = sa; op_b = sb; end
      IDX_V:   begin op_a = va; op_b = vb; end
      default: begin op_a = ya; op_b = yb; end
    endcase
    op_hi = (op_a > op_b) ? op_a : op_b;
    op_lo = (op_a > op_b) ? op_b : op_a;
  end

  // Ratio weight: 3 for density, 2 for population and variability.
  logic [TSUM_W-1:0] ratio_q, ratio_term;
  assign ratio_q    = TSUM_W'(div_rsp.quotient[SIM_W-1:0]);
  assign ratio_term = (idx == IDX_S) ? (ratio_q + (ratio_q << 1)) : (ratio_q << 1);

  // Shared multiplier: weight times max Y, then that times the ratio sum.
  logic [FIELD_W-1:0] ymax;
  logic [31:0]        mul_a;
  logic [TSUM_W-1:0]  mul_b;
  logic [PROD_W-1:0]  mul_p;

  assign ymax = (ya > yb) ? ya : yb;
  always_comb begin
    if (state == S_MUL1) begin
      mul_a = 32'(wgt);
      mul_b = TSUM_W'(ymax);
    end else begin
      mul_a = prod[31:0];
      mul_b = tsum;
    end
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Saturating numerator accumulate.
  logic [NUM_W:0]   num_sum;
  logic [NUM_W-1:0] num_next;
  assign num_sum  = {1'b0, weighted_numerator} + (NUM_W+1)'(prod);
  assign num_next = num_sum[NUM_W] ? {NUM_W{1'b1}} : num_sum[NUM_W-1:0];

  // Final divisor from the larger total.
  logic [TOTAL_W-1:0] tmax;
  assign tmax = (total_pop_a > total_pop_b) ? total_pop_a : total_pop_b;

  // Capped distance and similarity from the final quotient.
  logic [SIM_W-1:0] distance;
  assign distance = (div_rsp.quotient > QUO_W'(ONE_Q16)) ? ONE_Q16
                                                          : div_rsp.quotient[SIM_W-1:0];

  // Divider requests.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    if (state == S_RLAUNCH) begin
      div_req.start    = (op_hi != '0);
      div_req.dividend = DVD_W'({op_hi - op_lo, 16'h0000});
      div_req.divisor  = DVS_W'(op_hi);
    end else if (state == S_FLAUNCH) begin
      div_req.start    = (tmax != '0);
      div_req.dividend = weighted_numerator;
      div_req.divisor  = DVS_W'(tmax) * DIV_SCALE;
    end
  end

  assign busy = (state != S_IDLE);

  // Entry capture.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      ya     <= y_a;
      sa     <= s_a;
      va     <= v_a;
      yb     <= y_b;
      sb     <= s_b;
      vb     <= v_b;
      wgt    <= color_weight;
      last_r <= last;
    end
  end

  // Sequencer and accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      total_pop_a        <= '0;
      total_pop_b        <= '0;
      weighted_numerator <= '0;
      done               <= 1'b0;
      idx                <= IDX_Y;
      tsum               <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (!ignored) begin
              total_pop_a <= total_a_next;
              total_pop_b <= total_b_next;
            end
            idx  <= IDX_Y;
            tsum <= '0;
            if (!ignored && (y_a != '0 || y_b != '0)) begin
              state <= S_RLAUNCH;
            end else if (last) begin
              state <= S_FLAUNCH;
            end
          end
        end
        S_RLAUNCH: begin
          // A ratio whose larger value is zero counts as zero.
          if (op_hi != '0) begin
            state <= S_RWAIT;
          end else if (idx == IDX_V) begin
            state <= S_MUL1;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_RWAIT: begin
          if (div_rsp.done) begin
            tsum <= tsum + ratio_term;
            if (idx == IDX_V) begin
              state <= S_MUL1;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_RLAUNCH;
            end
          end
        end
        S_MUL1: begin
          prod  <= mul_p;
          state <= S_MUL2;
        end
        S_MUL2: begin
          prod  <= mul_p;
          state <= S_ACCUM;
        end
        S_ACCUM: begin
          weighted_numerator <= num_next;
          state <= last_r ? S_FLAUNCH : S_IDLE;
        end
        S_FLAUNCH: begin
          if (tmax != '0) begin
            state <= S_FWAIT;
          end else begin
            // Zero totals give full similarity.
            similarity         <= ONE_Q16;
            done               <= 1'b1;
            total_pop_a        <= '0;
            total_pop_b        <= '0;
            weighted_numerator <= '0;
            state              <= S_IDLE;
          end
        end
        S_FWAIT: begin
          if (div_rsp.done) begin
            similarity         <= ONE_Q16 - distance;
            done               <= 1'b1;
            total_pop_a        <= '0;
            total_pop_b        <= '0;
            weighted_numerator <= '0;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The result strobe lasts one cycle only.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // A result never exceeds 1.0.
  a_sim_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (similarity <= ONE_Q16))
    else $error("similarity above 1.0");

  // The divider only answers while the sequencer waits for it.
  a_div_expected: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_RWAIT || state == S_FWAIT))
    else $error("divider finished outside a wait state");

  // An entry that is not last never produces a result next cycle.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !last) |=> !done)
    else $error("result after an entry that is not last");

endmodule

`default_nettype wire
